[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mkd_pkg.sv]
// ----------------------------------------------------------------------------
// mkd_pkg
// Types, constants and the letter table of the Morse key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int MAX_SYMBOLS_DEF = 7;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int TIME_W          = 16;
  localparam int CHAR_W          = 7;
  localparam int CODE_LEN_W      = 3;
  localparam int CODE_PAT_W      = 5;
  localparam int CODE_COUNT      = 36;
  localparam int CFG_ADDR_W      = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_DOT_MIN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DASH_MIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP_MIN  = 2'd2;

  localparam logic [TIME_W-1:0] DOT_MIN_RST  = 16'd469;
  localparam logic [TIME_W-1:0] DASH_MIN_RST = 16'd3125;
  localparam logic [TIME_W-1:0] GAP_MIN_RST  = 16'd6250;

  localparam logic [CHAR_W-1:0] NO_MATCH_CHAR = 7'h2A;  // '*'

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DOT    = 2'd1,
    KIND_DASH   = 2'd2,
    KIND_LETTER = 2'd3
  } kind_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_ADDR_W-1:0] addr;
    logic [TIME_W-1:0]     data;
  } cfg_write_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] letter;
  } result_t;

  typedef struct packed {
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_PAT_W-1:0] pat;   // bit i is symbol i, 1 = dash
    logic [CHAR_W-1:0]     ch;
  } code_entry_t;

  localparam code_entry_t CODE_TABLE [CODE_COUNT] = '{
    '{3'd2, 5'b00010, 7'h41}, '{3'd4, 5'b00001, 7'h42}, '{3'd4, 5'b00101, 7'h43},
    '{3'd3, 5'b00001, 7'h44}, '{3'd1, 5'b00000, 7'h45}, '{3'd4, 5'b00100, 7'h46},
    '{3'd3, 5'b00011, 7'h47}, '{3'd4, 5'b00000, 7'h48}, '{3'd2, 5'b00000, 7'h49},
    '{3'd4, 5'b01110, 7'h4A}, '{3'd3, 5'b00101, 7'h4B}, '{3'd4, 5'b00010, 7'h4C},
    '{3'd2, 5'b00011, 7'h4D}, '{3'd2, 5'b00001, 7'h4E}, '{3'd3, 5'b00111, 7'h4F},
    '{3'd4, 5'b00110, 7'h50}, '{3'd4, 5'b01011, 7'h51}, '{3'd3, 5'b00010, 7'h52},
    '{3'd3, 5'b00000, 7'h53}, '{3'd1, 5'b00001, 7'h54}, '{3'd3, 5'b00100, 7'h55},
    '{3'd4, 5'b01000, 7'h56}, '{3'd3, 5'b00110, 7'h57}, '{3'd4, 5'b01001, 7'h58},
    '{3'd4, 5'b01101, 7'h59}, '{3'd4, 5'b00011, 7'h5A},
    '{3'd5, 5'b11110, 7'h31}, '{3'd5, 5'b11100, 7'h32}, '{3'd5, 5'b11000, 7'h33},
    '{3'd5, 5'b10000, 7'h34}, '{3'd5, 5'b00000, 7'h35}, '{3'd5, 5'b00001, 7'h36},
    '{3'd5, 5'b00011, 7'h37}, '{3'd5, 5'b00111, 7'h38}, '{3'd5, 5'b01111, 7'h39},
    '{3'd5, 5'b11111, 7'h30}
  };

  // Codes are unique, so at most one entry hits.
  function automatic logic [CHAR_W-1:0] lookup_letter(
    input logic [CODE_LEN_W-1:0] len,
    input logic [CODE_PAT_W-1:0] pat
  );
    logic [CHAR_W-1:0]     ch;
    logic [CODE_PAT_W-1:0] mask;
    logic                  hit;
    ch   = '0;
    hit  = 1'b0;
    mask = CODE_PAT_W'((6'd1 << len) - 6'd1);
    for (int i = 0; i < CODE_COUNT; i++) begin
      if (CODE_TABLE[i].len == len && CODE_TABLE[i].pat == (pat & mask)) begin
        ch  = ch | CODE_TABLE[i].ch;
        hit = 1'b1;
      end
    end
    return hit ? ch : NO_MATCH_CHAR;
  endfunction

endpackage

[sv/mkd_fifo.sv]
// ----------------------------------------------------------------------------
// mkd_fifo
// Small register queue with fall-through read of the oldest entry.
// ----------------------------------------------------------------------------
module mkd_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = mkd_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr;
  logic             rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/mkd_front.sv]
// ----------------------------------------------------------------------------
// mkd_front
// Holds thresholds and press time; classifies each key edge by duration.
// ----------------------------------------------------------------------------
module mkd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  mkd_pkg::cfg_write_t        cfg,
  input  logic                       take,
  input  logic                       is_release,
  input  logic [mkd_pkg::TIME_W-1:0] event_time,
  output mkd_pkg::kind_t             kind
);

  logic [mkd_pkg::TIME_W-1:0] dot_min;
  logic [mkd_pkg::TIME_W-1:0] dash_min;
  logic [mkd_pkg::TIME_W-1:0] gap_min;
  logic [mkd_pkg::TIME_W-1:0] press_time;
  logic [mkd_pkg::TIME_W-1:0] dur;

  assign dur = event_time - press_time;

  always_comb begin
    kind = mkd_pkg::KIND_NONE;
    if (is_release) begin
      if (dur >= dot_min && dur < dash_min) begin
        kind = mkd_pkg::KIND_DOT;
      end else if (dur >= dash_min && dur < gap_min) begin
        kind = mkd_pkg::KIND_DASH;
      end else if (dur >= gap_min) begin
        kind = mkd_pkg::KIND_LETTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min    <= mkd_pkg::DOT_MIN_RST;
      dash_min   <= mkd_pkg::DASH_MIN_RST;
      gap_min    <= mkd_pkg::GAP_MIN_RST;
      press_time <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.addr)
          mkd_pkg::REG_DOT_MIN:  dot_min  <= cfg.data;
          mkd_pkg::REG_DASH_MIN: dash_min <= cfg.data;
          mkd_pkg::REG_GAP_MIN:  gap_min  <= cfg.data;
          default: ;
        endcase
      end
      if (take && !is_release) begin
        press_time <= event_time;
      end
    end
  end

endmodule

[sv/mkd_back.sv]
// ----------------------------------------------------------------------------
// mkd_back
// Symbol buffer and letter lookup; turns each class into one result.
// ----------------------------------------------------------------------------
module mkd_back #(
  parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cls_valid,
  input  mkd_pkg::kind_t   cls_kind,
  output logic             cls_pop,
  input  logic             res_ready,
  output logic             res_push,
  output mkd_pkg::result_t res
);

  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  logic [MAX_SYMBOLS-1:0] pattern;
  logic [CW-1:0]          count;
  logic                   step;
  logic                   room;
  logic [mkd_pkg::CHAR_W-1:0] found;

  assign step     = cls_valid && res_ready;
  assign cls_pop  = step;
  assign res_push = step;
  assign room     = (count < CW'(MAX_SYMBOLS));

  always_comb begin
    if (count <= CW'(mkd_pkg::CODE_PAT_W)) begin
      found = mkd_pkg::lookup_letter(count[mkd_pkg::CODE_LEN_W-1:0],
                                     pattern[mkd_pkg::CODE_PAT_W-1:0]);
    end else begin
      found = mkd_pkg::NO_MATCH_CHAR;
    end
  end

  always_comb begin
    res.kind   = cls_kind;
    res.letter = (cls_kind == mkd_pkg::KIND_LETTER) ? found : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      count   <= '0;
    end else if (step) begin
      unique case (cls_kind)
        mkd_pkg::KIND_DOT: begin
          if (room) begin
            count <= count + 1'b1;
          end
        end
        mkd_pkg::KIND_DASH: begin
          if (room) begin
            pattern <= pattern | (MAX_SYMBOLS'(1) << count);
            count   <= count + 1'b1;
          end
        end
        mkd_pkg::KIND_LETTER: begin
          pattern <= '0;
          count   <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/morse_key_decoder_core.sv]
// ----------------------------------------------------------------------------
// morse_key_decoder_core
// Morse key decoder: key edges in, none/dot/dash/letter results out.
// ----------------------------------------------------------------------------
// channel   direction  handshake      payload
// input     in         push / full    is_release, event_time
// result    out        empty / pop    event_kind, letter
// config    in         cfg_we         cfg_addr, cfg_wdata
//
// One item per cycle sustained while results are popped. Each input goes by front
// classify into the class queue and back lookup into the result queue to the ports.
// rst is synchronous: thresholds return to defaults, press time and symbol
// buffer clear, both queues empty.
// full rises when the class queue fills behind a stalled result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module morse_key_decoder_core #(
  parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF,
  parameter int QUEUE_DEPTH = mkd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mkd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mkd_pkg::TIME_W-1:0]     cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic                           is_release,
  input  logic [mkd_pkg::TIME_W-1:0]     event_time,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     event_kind,
  output logic [mkd_pkg::CHAR_W-1:0]     letter
);

  localparam int KW = $bits(mkd_pkg::kind_t);
  localparam int RW = $bits(mkd_pkg::result_t);

  mkd_pkg::cfg_write_t cfg;
  mkd_pkg::kind_t      front_kind;
  mkd_pkg::kind_t      cls_kind;
  mkd_pkg::result_t    back_res;
  mkd_pkg::result_t    out_res;
  logic                take;
  logic                cls_full;
  logic                cls_empty;
  logic                cls_pop;
  logic [KW-1:0]       cls_dout;
  logic                res_full;
  logic                res_push;
  logic [RW-1:0]       res_dout;

  assign cfg.we   = cfg_we;
  assign cfg.addr = cfg_addr;
  assign cfg.data = cfg_wdata;

  assign full = cls_full;
  assign take = push && !cls_full;

  mkd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take       (take),
    .is_release (is_release),
    .event_time (event_time),
    .kind       (front_kind)
  );

  mkd_fifo #(.WIDTH(KW), .DEPTH(QUEUE_DEPTH)) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .din   (front_kind),
    .full  (cls_full),
    .pop   (cls_pop),
    .dout  (cls_dout),
    .empty (cls_empty)
  );

  assign cls_kind = mkd_pkg::kind_t'(cls_dout);

  mkd_back #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (!cls_empty),
    .cls_kind  (cls_kind),
    .cls_pop   (cls_pop),
    .res_ready (!res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  mkd_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign out_res    = mkd_pkg::result_t'(res_dout);
  assign event_kind = out_res.kind;
  assign letter     = out_res.letter;

  `ASSERT_IMPLIES(a_press_is_none, clk, rst, take && !is_release, front_kind == mkd_pkg::KIND_NONE, "press edge classified as a symbol")
  `ASSERT_IMPLIES(a_letter_only_on_decode, clk, rst, !empty && event_kind != mkd_pkg::KIND_LETTER, letter == '0, "letter set on non-decode result")
  `ASSERT_IMPLIES(a_back_no_overrun, clk, rst, res_push, !res_full && !cls_empty, "back stage moved without room or data")
  `ASSERT_NEXT(a_result_follows, clk, rst, res_push, !empty, "result transfer lost")

endmodule

[dv/tb_morse_key_decoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_key_decoder_core
// Self-checking bench for the Morse key decoder. Key press/release edges are
// pushed through the input queue, and a local decoder computes the kind and
// letter due for each edge. Every popped result is checked in order. Covers
// threshold edges, timestamp wrap, full symbol buffer and unknown codes.
// Threshold settings range from defaults through unordered and extreme ones.
// Sender bursts (random tests), receiver stalls throughout, one long hold-off.
// ----------------------------------------------------------------------------
module tb_morse_key_decoder_core;

  localparam int CLK_PERIOD    = 12;
  localparam int RST_CYCLES    = 7;
  localparam int SYMBOL_LIMIT  = mkd_pkg::MAX_SYMBOLS_DEF;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int TIME_W        = mkd_pkg::TIME_W;
  localparam int CHAR_W        = mkd_pkg::CHAR_W;
  localparam int CFG_ADDR_W    = mkd_pkg::CFG_ADDR_W;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam logic KEY_PRESS   = 1'b0;
  localparam logic KEY_RELEASE = 1'b1;

  typedef enum int {HOLD_SHORT, HOLD_DOT, HOLD_DASH, HOLD_END} hold_class_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [TIME_W-1:0]     cfg_wdata;
  logic                  push;
  logic                  full;
  logic                  is_release;
  logic [TIME_W-1:0]     event_time;
  logic                  empty;
  logic                  pop;
  logic [1:0]            event_kind;
  logic [CHAR_W-1:0]     letter;

  morse_key_decoder_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .full       (full),
    .is_release (is_release),
    .event_time (event_time),
    .empty      (empty),
    .pop        (pop),
    .event_kind (event_kind),
    .letter     (letter)
  );

  // decoder copy
  logic [TIME_W-1:0]       dot_min;
  logic [TIME_W-1:0]       dash_min;
  logic [TIME_W-1:0]       gap_min;
  logic [TIME_W-1:0]       last_press;
  logic [SYMBOL_LIMIT-1:0] symbols;
  int unsigned             symbol_cnt;

  mkd_pkg::result_t  expected_events[$];
  int                mismatches;
  int                results_seen;
  int                items_sent;
  int                hold_requests;
  int                burst_left;
  bit                idling_on;
  logic [TIME_W-1:0] key_clock;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("morse_key_decoder_core: mismatch");
    $finish;
  end

  // Walk the Morse tree: dot goes left, dash goes right.
  function automatic logic [CHAR_W-1:0] morse_char(logic [SYMBOL_LIMIT-1:0] pat,
                                                  int unsigned cnt);
    int       node;
    bit [7:0] ch;
    node = 1;
    if (cnt == 0 || cnt > 5) return mkd_pkg::NO_MATCH_CHAR;
    for (int k = 0; k < cnt; k++) node = 2 * node + int'(pat[k]);
    case (node)
      2: ch = "E";  3: ch = "T";  4: ch = "I";  5: ch = "A";  6: ch = "N";
      7: ch = "M";  8: ch = "S";  9: ch = "U"; 10: ch = "R"; 11: ch = "W";
      12: ch = "D"; 13: ch = "K"; 14: ch = "G"; 15: ch = "O"; 16: ch = "H";
      17: ch = "V"; 18: ch = "F"; 20: ch = "L"; 22: ch = "P"; 23: ch = "J";
      24: ch = "B"; 25: ch = "X"; 26: ch = "C"; 27: ch = "Y"; 28: ch = "Z";
      29: ch = "Q"; 32: ch = "5"; 33: ch = "4"; 35: ch = "3"; 39: ch = "2";
      47: ch = "1"; 48: ch = "6"; 56: ch = "7"; 60: ch = "8"; 62: ch = "9";
      63: ch = "0";
      default: ch = {1'b0, mkd_pkg::NO_MATCH_CHAR};
    endcase
    return ch[CHAR_W-1:0];
  endfunction

  function automatic void store_symbol(logic is_dash);
    if (symbol_cnt < SYMBOL_LIMIT) begin
      symbols[symbol_cnt] = is_dash;
      symbol_cnt++;
    end
  endfunction

  function automatic mkd_pkg::result_t predict_edge(logic rel, logic [TIME_W-1:0] t);
    mkd_pkg::result_t  r;
    logic [TIME_W-1:0] held;
    r.kind   = mkd_pkg::KIND_NONE;
    r.letter = '0;
    if (!rel) begin
      last_press = t;
    end else begin
      held = t - last_press;
      if (held >= dot_min && held < dash_min) begin
        r.kind = mkd_pkg::KIND_DOT;
        store_symbol(1'b0);
      end else if (held >= dash_min && held < gap_min) begin
        r.kind = mkd_pkg::KIND_DASH;
        store_symbol(1'b1);
      end else if (held >= gap_min) begin
        r.kind     = mkd_pkg::KIND_LETTER;
        r.letter   = morse_char(symbols, symbol_cnt);
        symbols    = '0;
        symbol_cnt = 0;
      end
    end
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] held_for(hold_class_t cls);
    int lo;
    int hi;
    int pick;
    case (cls)
      HOLD_SHORT: begin
        lo = 0;
        hi = int'(dot_min) - 1;
      end
      HOLD_DOT: begin
        lo = int'(dot_min);
        hi = int'(dash_min) - 1;
      end
      HOLD_DASH: begin
        lo = int'(dash_min);
        hi = int'(gap_min) - 1;
      end
      default: begin
        lo = int'(gap_min);
        hi = ($urandom_range(0, 7) == 0) ? 65535 : lo + 4000;
        if (hi > 65535) hi = 65535;
      end
    endcase
    if (hi < lo) return TIME_W'($urandom);
    pick = $urandom_range(0, 3);
    if (pick == 0) return TIME_W'(lo);
    if (pick == 1) return TIME_W'(hi);
    return TIME_W'($urandom_range(hi, lo));
  endfunction

  // Called at a clock edge; returns at the edge of the transfer, or after the gap.
  task automatic send_edge(logic rel, logic [TIME_W-1:0] t);
    int gap;
    push       <= 1'b1;
    is_release <= rel;
    event_time <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_events.push_back(predict_edge(rel, t));
    items_sent++;
    if (idling_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic key_stroke(logic [TIME_W-1:0] held);
    send_edge(KEY_PRESS, key_clock);
    send_edge(KEY_RELEASE, key_clock + held);
    key_clock = key_clock + held + TIME_W'($urandom_range(1, 3000));
  endtask

  task automatic send_letter(int n_symbols);
    for (int k = 0; k < n_symbols; k++) begin
      if ($urandom_range(0, 9) == 0) key_stroke(held_for(HOLD_SHORT));
      key_stroke(held_for($urandom_range(0, 1) ? HOLD_DASH : HOLD_DOT));
    end
    key_stroke(held_for(HOLD_END));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [TIME_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      mkd_pkg::REG_DOT_MIN:  dot_min  = data;
      mkd_pkg::REG_DASH_MIN: dash_min = data;
      mkd_pkg::REG_GAP_MIN:  gap_min  = data;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [TIME_W-1:0] dot, logic [TIME_W-1:0] dash,
                                logic [TIME_W-1:0] gap);
    wait_idle();
    write_reg(mkd_pkg::REG_DOT_MIN, dot);
    write_reg(mkd_pkg::REG_DASH_MIN, dash);
    write_reg(mkd_pkg::REG_GAP_MIN, gap);
    write_reg(REG_UNUSED, TIME_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n_items);
    int first;
    first = items_sent;
    while (items_sent - first < n_items) begin
      case ($urandom_range(0, 9))
        0, 1: send_edge(logic'($urandom_range(0, 1)), TIME_W'($urandom));
        2: key_stroke(held_for(hold_class_t'($urandom_range(0, 3))));
        default: send_letter(($urandom_range(0, 5) == 0) ? $urandom_range(6, 8)
                                                         : $urandom_range(1, 5));
      endcase
    end
  endtask

  // Reset thresholds: boundaries, stray release, double press, wrap.
  task automatic test_directed();
    idling_on = 1'b0;
    send_edge(KEY_RELEASE, 16'd0);
    send_edge(KEY_RELEASE, 16'd469);
    send_edge(KEY_PRESS, 16'd1000);
    send_edge(KEY_RELEASE, 16'd7250);
    send_edge(KEY_PRESS, 16'd8000);
    send_edge(KEY_RELEASE, 16'd8468);
    send_edge(KEY_PRESS, 16'd9000);
    send_edge(KEY_RELEASE, 16'd12124);
    send_edge(KEY_PRESS, 16'd13000);
    send_edge(KEY_RELEASE, 16'd16125);
    send_edge(KEY_PRESS, 16'd20000);
    send_edge(KEY_RELEASE, 16'd26249);
    send_edge(KEY_PRESS, 16'd30000);
    send_edge(KEY_RELEASE, 16'd29999);
    send_edge(KEY_PRESS, 16'd31000);
    send_edge(KEY_RELEASE, 16'd37250);
    send_edge(KEY_PRESS, 16'd65500);
    send_edge(KEY_RELEASE, 16'd500);
    send_edge(KEY_PRESS, 16'd600);
    send_edge(KEY_PRESS, 16'd700);
    send_edge(KEY_RELEASE, 16'd3900);
    send_edge(KEY_PRESS, 16'd4000);
    send_edge(KEY_RELEASE, 16'd65535);
    idling_on = 1'b1;
  endtask

  task automatic test_random_defaults();
    run_random(150);
  endtask

  task automatic test_small_thresholds();
    set_thresholds(16'd10, 16'd40, 16'd90);
    run_random(150);
  endtask

  task automatic test_backpressure();
    wait_idle();
    idling_on = 1'b0;
    hold_requests++;
    repeat (3) send_letter(3);
    wait_idle();
    idling_on = 1'b1;
  endtask

  task automatic test_unordered_thresholds();
    set_thresholds(16'd500, 16'd100, 16'd300);
    run_random(60);
  endtask

  task automatic test_extreme_thresholds();
    set_thresholds(16'd0, 16'd1, 16'd2);
    run_random(40);
    set_thresholds(16'd0, 16'd0, 16'd0);
    run_random(30);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(30);
    set_thresholds(16'd0, 16'h8000, 16'hFFFF);
    run_random(60);
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    push       = 1'b0;
    is_release = 1'b0;
    event_time = '0;
    dot_min    = mkd_pkg::DOT_MIN_RST;
    dash_min   = mkd_pkg::DASH_MIN_RST;
    gap_min    = mkd_pkg::GAP_MIN_RST;
    last_press = '0;
    symbols    = '0;
    symbol_cnt = 0;
    mismatches    = 0;
    results_seen  = 0;
    items_sent    = 0;
    hold_requests = 0;
    burst_left    = 1;
    idling_on     = 1'b0;
    key_clock     = '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_defaults();
    test_small_thresholds();
    test_backpressure();
    test_unordered_thresholds();
    test_extreme_thresholds();
    wait_idle();
    if (mismatches == 0) begin
      $display("morse_key_decoder_core: match");
    end else begin
      $display("morse_key_decoder_core: mismatch");
    end
    $finish;
  end

  // Result side: shifting stall masks, plus the long hold-off on request.
  initial begin : receiver
    logic [15:0] pattern;
    int          slot;
    int          holds_done;
    int          hold_left;
    pop        = 1'b0;
    pattern    = '1;
    slot       = 0;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (slot == 0) begin
          case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = 16'($urandom);
            2: pattern = 16'($urandom & $urandom);
            default: pattern = 16'($urandom | $urandom);
          endcase
        end
        pop  <= pattern[slot];
        slot = (slot + 1) % 16;
      end
    end
  end

  always @(posedge clk) begin : check_results
    mkd_pkg::result_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d unexpected, kind=%0d letter=%h",
                   $time, results_seen, event_kind, letter);
      end else begin
        want = expected_events.pop_front();
        if (event_kind !== want.kind || letter !== want.letter) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d expected kind=%0d letter=%h, got kind=%0d letter=%h",
                     $time, results_seen, want.kind, want.letter, event_kind, letter);
        end
      end
    end
  end

endmodule
